// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the calendar conversion block.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DOTC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dotc assertion failed");

// Next-cycle implication, checked outside reset.
`define DOTC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dotc assertion failed");

`endif

// ----- rtl/dotc_pkg.sv -----
// Package for the day ordinal to calendar converter: word types, calendar constants
// and month tables. No dependencies.
package dotc_pkg;

   localparam int DAY_W  = 22;
   localparam int SEC_W  = 17;
   localparam int YEAR_W = 14;

   localparam int unsigned DAYS_400Y = 146097;
   localparam int unsigned DAYS_100Y = 36524;
   localparam int unsigned DAYS_4Y   = 1461;
   localparam int unsigned DAYS_1Y   = 365;
   localparam int unsigned SECS_DAY  = 86400;
   localparam int unsigned SECS_HOUR = 3600;
   localparam int unsigned SECS_MIN  = 60;

   // Fraction bits of the reciprocal used by the constant dividers.
   localparam int RECIP_SHIFT = 32;

   localparam logic [8:0] CUM_DAYS [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243,
      9'd273, 9'd304, 9'd334, 9'd334, 9'd334, 9'd334
   };

   localparam logic [4:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30,
      5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   typedef struct packed {
      logic [DAY_W-1:0] day_number;
      logic [SEC_W-1:0] second_of_day;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [3:0]        month;
      logic [4:0]        day_of_month;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
   } rsp_type;

endpackage

// ----- rtl/dotc_cdiv.sv -----
// Two-stage divider by a constant: reciprocal multiply, then a one-step correction.
// Depends on dotc_pkg for the reciprocal scaling.
module dotc_cdiv #(
   parameter int          NUM_W   = dotc_pkg::DAY_W,
   parameter int unsigned DIVISOR = dotc_pkg::DAYS_400Y,
   parameter int          QUOT_W  = 5,
   parameter int          REM_W   = 18
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num,
   output logic [QUOT_W-1:0] quot,
   output logic [REM_W-1:0]  rem
);

   localparam logic [63:0] RECIP  = (64'd1 << dotc_pkg::RECIP_SHIFT) / 64'(DIVISOR);
   localparam int          RECIP_W = $clog2(RECIP + 64'd1);
   localparam int          PROD_W  = NUM_W + RECIP_W;
   localparam logic [NUM_W-1:0] DIV_C = NUM_W'(DIVISOR);

   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] q_est_in, q_est_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  back, diff;
   logic              fix;
   logic [QUOT_W-1:0] quot_in, quot_ff;
   logic [REM_W-1:0]  rem_in, rem_ff;

   // The floor reciprocal underestimates the quotient by at most one.
   assign prod     = PROD_W'(num) * PROD_W'(RECIP);
   assign q_est_in = QUOT_W'(prod >> dotc_pkg::RECIP_SHIFT);

   assign back    = NUM_W'(q_est_ff * DIVISOR);
   assign diff    = num_ff - back;
   assign fix     = (diff >= DIV_C);
   assign quot_in = q_est_ff + QUOT_W'(fix);
   assign rem_in  = fix ? REM_W'(diff - DIV_C) : REM_W'(diff);

   always_ff @(posedge clock) begin
      if (en) begin
         q_est_ff <= q_est_in;
         num_ff   <= num;
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
      end
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/day_ordinal_to_calendar.sv -----
// Top level of the day ordinal to calendar converter (nine-stage pipeline).
// Depends on dotc_pkg, dotc_cdiv and assert_macros.svh.
//
//   channel  direction  word type           handshake
//   req      in         dotc_pkg::req_type  req_valid / req_ready
//   rsp      out        dotc_pkg::rsp_type  rsp_valid / rsp_ready
//
// rsp_valid rises once an accepted word has passed all stages; one word enters per cycle unless
// rsp is stalled. The depth is set by the chain of 400-year and 4-year constant dividers (two
// stages each, with the hour and minute dividers beside them) plus five single stages.
// Reset clears only the stage valid bits; payload registers are not reset.
// All stages advance together whenever the output register is empty or being taken,
// so a stall on rsp freezes the whole pipeline and no word is lost or repeated.
`include "assert_macros.svh"

module day_ordinal_to_calendar (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dotc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dotc_pkg::rsp_type rsp_data
);

   localparam int NSTAGE = 9;
   localparam int YW     = dotc_pkg::YEAR_W;

   logic              adv;
   logic [NSTAGE-1:0] vld_in, vld_ff;

   // A held output word freezes every stage; otherwise all stages move together.
   assign adv       = !vld_ff[NSTAGE-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage A: zero-based day offset and second count reduced into one day.
   logic [dotc_pkg::DAY_W-1:0] a_off_in, a_off_ff;
   logic [dotc_pkg::SEC_W-1:0] a_sec_in, a_sec_ff;

   assign a_off_in = (req_data.day_number == '0) ? '0 : req_data.day_number - 22'd1;
   assign a_sec_in = (req_data.second_of_day >= dotc_pkg::SEC_W'(dotc_pkg::SECS_DAY))
                   ? req_data.second_of_day - dotc_pkg::SEC_W'(dotc_pkg::SECS_DAY)
                   : req_data.second_of_day;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_off_ff <= a_off_in;
         a_sec_ff <= a_sec_in;
      end
   end

   // Stages B and C: 400-year periods and hours.
   logic [4:0]  c_q400;
   logic [17:0] c_r400;
   logic [4:0]  c_hour;
   logic [11:0] c_rsec;

   dotc_cdiv #(
      .NUM_W(dotc_pkg::DAY_W), .DIVISOR(dotc_pkg::DAYS_400Y), .QUOT_W(5), .REM_W(18)
   ) u_div400 (
      .clock(clock), .en(adv), .num(a_off_ff), .quot(c_q400), .rem(c_r400)
   );

   dotc_cdiv #(
      .NUM_W(dotc_pkg::SEC_W), .DIVISOR(dotc_pkg::SECS_HOUR), .QUOT_W(5), .REM_W(12)
   ) u_div3600 (
      .clock(clock), .en(adv), .num(a_sec_ff), .quot(c_hour), .rem(c_rsec)
   );

   // Stage D: 100-year periods by comparison. The last day of a 400-year cycle
   // yields a count of four.
   logic [2:0]  d_q100_in, d_q100_ff;
   logic [17:0] d_sub;
   logic [15:0] d_r100_in, d_r100_ff;
   logic [YW-1:0] d_yr_in, d_yr_ff;
   logic [4:0]  d_hour_ff;
   logic [11:0] d_rsec_ff;

   always_comb begin
      if (c_r400 >= 18'(4 * dotc_pkg::DAYS_100Y)) begin
         d_q100_in = 3'd4;
         d_sub     = 18'(4 * dotc_pkg::DAYS_100Y);
      end else if (c_r400 >= 18'(3 * dotc_pkg::DAYS_100Y)) begin
         d_q100_in = 3'd3;
         d_sub     = 18'(3 * dotc_pkg::DAYS_100Y);
      end else if (c_r400 >= 18'(2 * dotc_pkg::DAYS_100Y)) begin
         d_q100_in = 3'd2;
         d_sub     = 18'(2 * dotc_pkg::DAYS_100Y);
      end else if (c_r400 >= 18'(dotc_pkg::DAYS_100Y)) begin
         d_q100_in = 3'd1;
         d_sub     = 18'(dotc_pkg::DAYS_100Y);
      end else begin
         d_q100_in = 3'd0;
         d_sub     = 18'd0;
      end
   end

   assign d_r100_in = 16'(c_r400 - d_sub);
   assign d_yr_in   = YW'(c_q400) * YW'(400) + YW'(d_q100_in) * YW'(100);

   always_ff @(posedge clock) begin
      if (adv) begin
         d_q100_ff <= d_q100_in;
         d_r100_ff <= d_r100_in;
         d_yr_ff   <= d_yr_in;
         d_hour_ff <= c_hour;
         d_rsec_ff <= c_rsec;
      end
   end

   // Stages E and F: 4-year periods and minutes.
   logic [4:0]  f_q4;
   logic [10:0] f_r4;
   logic [5:0]  f_min;
   logic [5:0]  f_sec;

   dotc_cdiv #(
      .NUM_W(16), .DIVISOR(dotc_pkg::DAYS_4Y), .QUOT_W(5), .REM_W(11)
   ) u_div1461 (
      .clock(clock), .en(adv), .num(d_r100_ff), .quot(f_q4), .rem(f_r4)
   );

   dotc_cdiv #(
      .NUM_W(12), .DIVISOR(dotc_pkg::SECS_MIN), .QUOT_W(6), .REM_W(6)
   ) u_div60 (
      .clock(clock), .en(adv), .num(d_rsec_ff), .quot(f_min), .rem(f_sec)
   );

   logic [2:0]    e_q100_ff, f_q100_ff;
   logic [YW-1:0] e_yr_ff, f_yr_ff;
   logic [4:0]    e_hour_ff, f_hour_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e_q100_ff <= d_q100_ff;
         e_yr_ff   <= d_yr_ff;
         e_hour_ff <= d_hour_ff;
         f_q100_ff <= e_q100_ff;
         f_yr_ff   <= e_yr_ff;
         f_hour_ff <= e_hour_ff;
      end
   end

   // Stage G: single years by comparison, the year sum, the leap flag and the
   // 31 December case where a period count reaches four.
   logic [2:0]    g_q1;
   logic [10:0]   g_sub;
   logic [8:0]    g_r1_in, g_r1_ff;
   logic [YW-1:0] g_yr_in, g_yr_ff;
   logic          g_leap_in, g_leap_ff;
   logic          g_special_in, g_special_ff;
   logic [4:0]    g_hour_ff;
   logic [5:0]    g_min_ff, g_sec_ff;

   always_comb begin
      if (f_r4 >= 11'(4 * dotc_pkg::DAYS_1Y)) begin
         g_q1  = 3'd4;
         g_sub = 11'(4 * dotc_pkg::DAYS_1Y);
      end else if (f_r4 >= 11'(3 * dotc_pkg::DAYS_1Y)) begin
         g_q1  = 3'd3;
         g_sub = 11'(3 * dotc_pkg::DAYS_1Y);
      end else if (f_r4 >= 11'(2 * dotc_pkg::DAYS_1Y)) begin
         g_q1  = 3'd2;
         g_sub = 11'(2 * dotc_pkg::DAYS_1Y);
      end else if (f_r4 >= 11'(dotc_pkg::DAYS_1Y)) begin
         g_q1  = 3'd1;
         g_sub = 11'(dotc_pkg::DAYS_1Y);
      end else begin
         g_q1  = 3'd0;
         g_sub = 11'd0;
      end
   end

   assign g_r1_in      = 9'(f_r4 - g_sub);
   assign g_yr_in      = f_yr_ff + YW'(f_q4) * YW'(4) + YW'(g_q1);
   assign g_leap_in    = (g_q1 == 3'd3) && ((f_q4 != 5'd24) || (f_q100_ff == 3'd3));
   assign g_special_in = (g_q1 == 3'd4) || (f_q100_ff == 3'd4);

   always_ff @(posedge clock) begin
      if (adv) begin
         g_r1_ff      <= g_r1_in;
         g_yr_ff      <= g_yr_in;
         g_leap_ff    <= g_leap_in;
         g_special_ff <= g_special_in;
         g_hour_ff    <= f_hour_ff;
         g_min_ff     <= f_min;
         g_sec_ff     <= f_sec;
      end
   end

   // Stage H: month estimate from the day of year, the days before that month,
   // the same for the month before it, and whether the estimate overshoots.
   logic [3:0]    h_mon_in, h_mon_ff;
   logic [3:0]    h_mon_m1;
   logic [8:0]    h_before_in, h_before_ff;
   logic [8:0]    h_lo_in, h_lo_ff;
   logic          h_over_in, h_over_ff;
   logic [8:0]    h_r1_ff;
   logic [YW-1:0] h_yr_ff;
   logic          h_special_ff;
   logic [4:0]    h_hour_ff;
   logic [5:0]    h_min_ff, h_sec_ff;

   assign h_mon_in    = 4'((10'(g_r1_ff) + 10'd50) >> 5);
   assign h_mon_m1    = h_mon_in - 4'd1;
   assign h_before_in = dotc_pkg::CUM_DAYS[h_mon_in]
                      + 9'((h_mon_in > 4'd2) && g_leap_ff);
   assign h_lo_in     = h_before_in - 9'(dotc_pkg::MONTH_LEN[h_mon_m1])
                      - 9'((h_mon_m1 == 4'd2) && g_leap_ff);
   assign h_over_in   = (h_before_in > g_r1_ff) && (h_mon_in > 4'd1);

   always_ff @(posedge clock) begin
      if (adv) begin
         h_mon_ff     <= h_mon_in;
         h_before_ff  <= h_before_in;
         h_lo_ff      <= h_lo_in;
         h_over_ff    <= h_over_in;
         h_r1_ff      <= g_r1_ff;
         h_yr_ff      <= g_yr_ff;
         h_special_ff <= g_special_ff;
         h_hour_ff    <= g_hour_ff;
         h_min_ff     <= g_min_ff;
         h_sec_ff     <= g_sec_ff;
      end
   end

   // Output stage: apply the month correction, or force 31 December of the
   // previous year for the end-of-cycle day.
   dotc_pkg::rsp_type o_data_in, o_data_ff;
   logic [8:0]        o_before;

   assign o_before = h_over_ff ? h_lo_ff : h_before_ff;

   always_comb begin
      o_data_in.hour   = h_hour_ff;
      o_data_in.minute = h_min_ff;
      o_data_in.second = h_sec_ff;
      if (h_special_ff) begin
         o_data_in.year         = h_yr_ff - YW'(1);
         o_data_in.month        = 4'd12;
         o_data_in.day_of_month = 5'd31;
      end else begin
         o_data_in.year         = h_yr_ff;
         o_data_in.month        = h_over_ff ? h_mon_ff - 4'd1 : h_mon_ff;
         o_data_in.day_of_month = 5'(h_r1_ff - o_before + 9'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_data_ff <= o_data_in;
      end
   end

   assign rsp_valid = vld_ff[NSTAGE-1];
   assign rsp_data  = o_data_ff;

   // Range checks on the divider remainders and on the delivered word.
   logic div_rem_ok;
   logic rsp_in_range;

   assign div_rem_ok   = (c_r400 < 18'(dotc_pkg::DAYS_400Y))
                       && (c_rsec < 12'(dotc_pkg::SECS_HOUR));
   assign rsp_in_range = (rsp_data.month >= 4'd1) && (rsp_data.month <= 4'd12)
                       && (rsp_data.day_of_month >= 5'd1) && (rsp_data.hour <= 5'd23)
                       && (rsp_data.minute <= 6'd59) && (rsp_data.second <= 6'd59);

   // A held result must hold back new words.
   `DOTC_ASSERT_NOW(a_stall_blocks_input, rsp_valid && !rsp_ready, !req_ready)
   // An accepted word occupies the first stage next cycle.
   `DOTC_ASSERT_NEXT(a_accept_fills_first, req_valid && req_ready, vld_ff[0])
   // The 400-year and hour dividers leave remainders below their divisors.
   `DOTC_ASSERT_NOW(a_div_rem_range, vld_ff[2], div_rem_ok)
   // Every delivered word has a month of 1 to 12, a nonzero day and a time of day in range.
   `DOTC_ASSERT_NOW(a_rsp_ranges, rsp_valid, rsp_in_range)

endmodule
